// ===== hdl/mcopt_pkg.sv =====
// Package of shared constants and types for the multi-channel output pattern timer.
`default_nettype none
package mcopt_pkg;

    // Widest pin row the block supports and field widths.
    localparam int MAX_PINS     = 24;
    localparam int IDX_W        = 5;
    localparam int MODE_W       = 3;
    localparam int COUNT_W      = 8;

    // Item types.
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SET    = 1'b1;

    // Pin mode codes. Codes 5 to 7 are stored but leave the pin inactive.
    localparam logic [MODE_W-1:0] MODE_LOW   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HIGH  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OSC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DLOW  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DHIGH = 3'd4;

    // Command broadcast from the top level to every pin lane.
    typedef struct packed {
        logic               tick;
        logic               load;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
    } t_lane_cmd;

endpackage
`default_nettype wire

// ===== hdl/mcopt_pin.sv =====
// One pin lane: mode, counter, reload value and output level of a single pin.
`default_nettype none
module mcopt_pin
    import mcopt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lane_cmd i_cmd,
    output logic           o_level_next
);

    logic [MODE_W-1:0]  r_mode,   n_mode;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic [COUNT_W-1:0] r_reload, n_reload;
    logic               r_level,  n_level;

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_reload = r_reload;
        n_level  = r_level;
        if (i_cmd.load) begin
            n_mode = i_cmd.mode;
            case (i_cmd.mode)
                MODE_OSC: begin
                    n_count  = i_cmd.count;
                    n_reload = i_cmd.count;
                    n_level  = 1'b1;
                end
                MODE_DLOW: begin
                    n_count  = i_cmd.count;
                    n_reload = '0;
                    n_level  = 1'b1;
                end
                MODE_DHIGH: begin
                    n_count  = i_cmd.count;
                    n_reload = '0;
                    n_level  = 1'b0;
                end
                MODE_HIGH: begin
                    n_count  = '0;
                    n_reload = '0;
                    n_level  = 1'b1;
                end
                MODE_LOW: begin
                    n_count  = '0;
                    n_reload = '0;
                    n_level  = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.tick && (r_mode inside {MODE_OSC, MODE_DLOW, MODE_DHIGH})) begin
            if (r_count == '0) begin
                n_level = ~r_level;
                if (r_mode == MODE_OSC) begin
                    n_count = r_reload;
                end else if (r_mode == MODE_DHIGH) begin
                    n_mode = MODE_HIGH;
                end else begin
                    n_mode = MODE_LOW;
                end
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LOW;
            r_count  <= '0;
            r_reload <= '0;
            r_level  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_reload <= n_reload;
            r_level  <= n_level;
        end
    end

    assign o_level_next = n_level;

endmodule
`default_nettype wire

// ===== hdl/multi_channel_output_pattern_timer_top.sv =====
// Top level of the multi-channel output pattern timer: item registers, pin lanes, result register.
`default_nettype none
// The block drives PINS output levels, each pin in steady low, steady high, oscillating,
// delayed-low or delayed-high mode. A set item loads one pin's mode and count; a tick item
// advances every active pin at once, each phase lasting count plus one ticks. Every item
// returns one result carrying the levels of all pins after that item, with bits at PINS and
// above held at zero. An accepted item is held in an input register and is applied to all pin
// lanes in parallel once the result register is free or being emptied; its result is loaded
// into the result register at the end of the cycle in which it is applied. One item is taken
// in every cycle while the result side keeps up. The result register lets a new item be taken
// while the previous result is still waiting. Set items for a pin index at or beyond PINS
// change nothing, and the unused mode codes are stored but leave the pin holding its level.
module multi_channel_output_pattern_timer_top
    import mcopt_pkg::*;
#(
    parameter int PINS = MAX_PINS
)
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_req_type,
    input  wire logic [IDX_W-1:0]    i_pin_index,
    input  wire logic [MODE_W-1:0]   i_pin_mode,
    input  wire logic [COUNT_W-1:0]  i_tick_count,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [MAX_PINS-1:0]      o_pin_levels
);

    // Input register holding one accepted item.
    logic               r_in_valid;
    logic               r_req_type;
    logic [IDX_W-1:0]   r_pin_index;
    logic [MODE_W-1:0]  r_pin_mode;
    logic [COUNT_W-1:0] r_tick_count;

    // Result register.
    logic                r_out_valid;
    logic [MAX_PINS-1:0] r_pin_levels;

    logic                w_fire;
    logic [MAX_PINS-1:0] w_levels_next;

    // The held item is applied whenever the result register is free or being emptied.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type   <= i_req_type;
            r_pin_index  <= i_pin_index;
            r_pin_mode   <= i_pin_mode;
            r_tick_count <= i_tick_count;
        end
    end

    // One lane per pin; each lane sees the shared command with its own load strobe.
    genvar g_pin;
    generate
        for (g_pin = 0; g_pin < MAX_PINS; g_pin++) begin : g_lane
            if (g_pin < PINS) begin : g_used
                t_lane_cmd w_cmd;

                assign w_cmd.tick  = w_fire && (r_req_type == REQ_TICK);
                assign w_cmd.load  = w_fire && (r_req_type == REQ_SET)
                                     && (r_pin_index == IDX_W'(g_pin));
                assign w_cmd.mode  = r_pin_mode;
                assign w_cmd.count = r_tick_count;

                mcopt_pin u_pin (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_cmd        (w_cmd),
                    .o_level_next (w_levels_next[g_pin])
                );
            end else begin : g_unused
                // Pins beyond PINS always read low.
                assign w_levels_next[g_pin] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pin_levels <= w_levels_next;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pin_levels = r_pin_levels;

endmodule
`default_nettype wire

// ===== tb/sv/multi_channel_output_pattern_timer_top_test.sv =====
// Self-checking testbench for the multi-channel output pattern timer top level.
module multi_channel_output_pattern_timer_top_test;
    import mcopt_pkg::*;

    // The block is built with its full row of pins, so indexes 24 to 31 are out of range.
    localparam int PIN_ROW = MAX_PINS;

    // Mode codes with no meaning of their own. A pin given one of these keeps its level.
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // Random part: item count, where the long result stall and the drain pause fall, and
    // how many items at the end run with no idling on either side.
    localparam int ITEM_TARGET  = 1800;
    localparam int HOLD_AT      = 600;
    localparam int DRAIN_AT     = 1200;
    localparam int CALM_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 5000;

    // Tracks the pin state as the block should hold it, and the levels still owed by the
    // block, one entry per accepted item in order of acceptance.
    class pin_level_book;
        logic [MODE_W-1:0]   mode_q   [MAX_PINS];
        logic [COUNT_W-1:0]  count_q  [MAX_PINS];
        logic [COUNT_W-1:0]  reload_q [MAX_PINS];
        logic                level_q  [MAX_PINS];
        logic [MAX_PINS-1:0] levels_due [$];
        int                  pin_count;
        int                  faults;

        function new(int pins);
            pin_count = pins;
            faults    = 0;
            for (int p = 0; p < MAX_PINS; p++) begin
                mode_q[p]   = MODE_LOW;
                count_q[p]  = '0;
                reload_q[p] = '0;
                level_q[p]  = 1'b0;
            end
        endfunction

        // Applies one accepted item to the tracked state and queues the levels it yields.
        function void note_item(logic rq, logic [IDX_W-1:0] idx, logic [MODE_W-1:0] md,
                                logic [COUNT_W-1:0] cnt);
            logic [MAX_PINS-1:0] lv;
            lv = '0;
            if (rq == REQ_TICK) begin
                for (int p = 0; p < pin_count; p++) begin
                    if (mode_q[p] == MODE_OSC || mode_q[p] == MODE_DLOW ||
                        mode_q[p] == MODE_DHIGH) begin
                        if (count_q[p] == '0) begin
                            level_q[p] = ~level_q[p];
                            if (mode_q[p] == MODE_OSC)
                                count_q[p] = reload_q[p];
                            else if (mode_q[p] == MODE_DHIGH)
                                mode_q[p] = MODE_HIGH;
                            else
                                mode_q[p] = MODE_LOW;
                        end else begin
                            count_q[p] = count_q[p] - 1'b1;
                        end
                    end
                end
            end else if (int'(idx) < pin_count) begin
                mode_q[idx] = md;
                case (md)
                    MODE_OSC: begin
                        count_q[idx] = cnt; reload_q[idx] = cnt; level_q[idx] = 1'b1;
                    end
                    MODE_DLOW: begin
                        count_q[idx] = cnt; reload_q[idx] = '0; level_q[idx] = 1'b1;
                    end
                    MODE_DHIGH: begin
                        count_q[idx] = cnt; reload_q[idx] = '0; level_q[idx] = 1'b0;
                    end
                    MODE_HIGH: begin
                        count_q[idx] = '0; reload_q[idx] = '0; level_q[idx] = 1'b1;
                    end
                    MODE_LOW: begin
                        count_q[idx] = '0; reload_q[idx] = '0; level_q[idx] = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            for (int p = 0; p < pin_count; p++)
                lv[p] = level_q[p];
            levels_due.push_back(lv);
        endfunction

        // Compares one accepted result with the oldest levels still owed.
        function void check_levels(logic [MAX_PINS-1:0] got);
            logic [MAX_PINS-1:0] want;
            if (levels_due.size() == 0) begin
                $error("pin_levels: result with nothing expected, actual %h", got);
                faults++;
            end else begin
                want = levels_due.pop_front();
                if (got !== want) begin
                    $error("pin_levels: expected %h, actual %h", want, got);
                    faults++;
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_req_type;
    logic [IDX_W-1:0]    i_pin_index;
    logic [MODE_W-1:0]   i_pin_mode;
    logic [COUNT_W-1:0]  i_tick_count;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [MAX_PINS-1:0] o_pin_levels;

    pin_level_book book = new(PIN_ROW);

    // Handshake between the item sender and the result receiver: a request for one long
    // stall of the result side, and the flag that switches idling off near the end.
    bit hold_request = 1'b0;
    bit calm         = 1'b0;
    int items_sent   = 0;

    multi_channel_output_pattern_timer_top #(
        .PINS(PIN_ROW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_pin_index (i_pin_index),
        .i_pin_mode  (i_pin_mode),
        .i_tick_count(i_tick_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pin_levels(o_pin_levels)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A correct run needs well under a tenth of this, even with every gap at its longest.
    initial begin
        #2000000;
        $display("multi_channel_output_pattern_timer_top_test NOT OK");
        $finish;
    end

    // Lowers the input valid and lets the given number of cycles go by.
    task automatic pause_sender(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Offers one item and holds it steady until the block takes it. Signals are sampled
    // just after the edge, so they still carry the values that the edge itself saw.
    task automatic offer_item(logic rq, logic [IDX_W-1:0] idx, logic [MODE_W-1:0] md,
                              logic [COUNT_W-1:0] cnt);
        i_in_valid   <= 1'b1;
        i_req_type   <= rq;
        i_pin_index  <= idx;
        i_pin_mode   <= md;
        i_tick_count <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.note_item(rq, idx, md, cnt);
    endtask

    // Sends one item, possibly after a random idle burst. Set items aimed past the end of
    // the pin row change no pin in the block and so are not counted.
    task automatic push_item(logic rq, logic [IDX_W-1:0] idx, logic [MODE_W-1:0] md,
                             logic [COUNT_W-1:0] cnt);
        if (!calm && $urandom_range(0, 9) == 0)
            pause_sender($urandom_range(1, 16));
        offer_item(rq, idx, md, cnt);
        if (!(rq == REQ_SET && int'(idx) >= PIN_ROW))
            items_sent++;
    endtask

    // A tick whose unused fields carry random values, which the block must ignore.
    task automatic push_tick();
        push_item(REQ_TICK, IDX_W'($urandom_range(0, 31)), MODE_W'($urandom_range(0, 7)),
                  COUNT_W'($urandom()));
    endtask

    // Result side: checks every accepted result and stalls in random bursts. A long stall,
    // when the sender asks for one, is counted out here while items keep arriving, so that
    // the block fills up and has to hold off its input.
    initial begin : result_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                book.check_levels(o_pin_levels);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Item side: reset, a directed opening, then random sequences, then the wind-down.
    initial begin : item_side
        bit                 hold_done;
        bit                 drain_done;
        int                 drain_cycles;
        logic [IDX_W-1:0]   idx;
        logic [MODE_W-1:0]  md;
        logic [COUNT_W-1:0] cnt;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= REQ_TICK;
        i_pin_index  <= '0;
        i_pin_mode   <= MODE_LOW;
        i_tick_count <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. A tick straight after reset, with every unused field at its top
        // value, must leave all pins low.
        push_item(REQ_TICK, 5'd31, MODE_SPARE_7, 8'd255);
        // An oscillating pin with a zero count toggles on every tick.
        push_item(REQ_SET, 5'd0, MODE_OSC, 8'd0);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        // Both delay modes on the top pins and steady high on pin 1; the count of a steady mode is
        // thrown away.
        push_item(REQ_SET, 5'd23, MODE_DLOW, 8'd1);
        push_item(REQ_SET, 5'd22, MODE_DHIGH, 8'd0);
        push_item(REQ_SET, 5'd1, MODE_HIGH, 8'd255);
        // Pins beyond the row: nothing changes, but a result still comes back.
        push_item(REQ_SET, 5'd24, MODE_OSC, 8'd5);
        push_item(REQ_SET, 5'd31, MODE_HIGH, 8'd0);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        // Spare mode codes freeze a pin at whatever level it had, high or low.
        push_item(REQ_SET, 5'd1, MODE_SPARE_5, 8'd9);
        push_item(REQ_SET, 5'd0, MODE_SPARE_7, 8'd255);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        push_item(REQ_SET, 5'd2, MODE_OSC, 8'd255);
        push_item(REQ_SET, 5'd1, MODE_LOW, 8'd128);
        push_item(REQ_SET, 5'd3, MODE_SPARE_6, 8'd0);
        push_item(REQ_TICK, 5'd0, MODE_LOW, 8'd0);
        push_item(REQ_SET, 5'd2, MODE_DHIGH, 8'd255);
        push_item(REQ_TICK, 5'd31, MODE_SPARE_7, 8'd255);

        // Random part. Most sequences load a few pins with legal modes and short counts and
        // then tick them through several phases; now and then a count is long. The rest is
        // noise: any item type with any field values, pins out of range and spare codes too.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    idx = IDX_W'($urandom_range(0, PIN_ROW - 1));
                    md  = MODE_W'($urandom_range(0, 4));
                    cnt = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom())
                                                       : COUNT_W'($urandom_range(0, 7));
                    push_item(REQ_SET, idx, md, cnt);
                end
                repeat ($urandom_range(1, 20)) push_tick();
            end else begin
                repeat ($urandom_range(1, 4))
                    push_item(1'($urandom()), IDX_W'($urandom_range(0, 31)),
                              MODE_W'($urandom_range(0, 7)), COUNT_W'($urandom()));
            end

            // Once, stall the result side for a long while and keep sending meanwhile.
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
            end
            // Once, stop sending until every owed result has come back.
            if (!drain_done && items_sent >= DRAIN_AT) begin
                drain_done = 1'b1;
                i_in_valid <= 1'b0;
                while (book.levels_due.size() != 0) @(posedge i_clk);
            end
            if (items_sent >= ITEM_TARGET - CALM_ITEMS)
                calm = 1'b1;
        end

        // Wind-down: wait, within a limit, for the last results, then wait on so that a stray
        // extra result would still be seen.
        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (book.levels_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (book.levels_due.size() != 0) begin
            $error("pin_levels: %0d results never arrived", book.levels_due.size());
            book.faults++;
        end
        if (book.faults == 0) begin
            $display("multi_channel_output_pattern_timer_top_test OK");
        end else begin
            $display("multi_channel_output_pattern_timer_top_test NOT OK");
        end
        $finish;
    end

endmodule
